// ----- rtl/rd32_pkg.sv -----
// ---------------------------------------------------------------------------
// rd32_pkg
// Shared types and constants for the pipelined 32 by 16 restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none

package rd32_pkg;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 17;
    localparam int QUOT_W     = 17;
    localparam int REM_W      = 16;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // control that travels with every request down the pipe
    typedef struct packed {
        logic    valid;
        logic    minus;
        t_status status;
    } t_ctrl;

endpackage

`default_nettype wire

// ----- rtl/rd32_front.sv -----
// ---------------------------------------------------------------------------
// rd32_front
// Two entry stages: operand magnitudes, then zero and overflow checks and
// the initial partial remainder.
// ---------------------------------------------------------------------------
`default_nettype none

module rd32_front #(
    parameter int W = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic [rd32_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  wire logic [rd32_pkg::DIVISOR_W-1:0]      i_divisor,
    output rd32_pkg::t_ctrl                          o_ctrl,
    output logic [W-1:0]                             o_rem,
    output logic [W-1:0]                             o_low,
    output logic [W-1:0]                             o_d
);

    // stage a: magnitudes
    logic                                r_valid_a;
    logic                                r_minus_a;
    logic [rd32_pkg::DIVIDEND_W-1:0]     r_mag_a;
    logic [rd32_pkg::DIVISOR_W-1:0]      r_mag_b;
    logic [rd32_pkg::DIVIDEND_W-1:0]     n_mag_a;
    logic [rd32_pkg::DIVISOR_W-1:0]      n_mag_b;

    // stage b: checks
    rd32_pkg::t_ctrl                     r_ctrl;
    rd32_pkg::t_ctrl                     n_ctrl;
    logic [W-1:0]                        r_rem;
    logic [W-1:0]                        r_low;
    logic [W-1:0]                        r_d;

    logic [W+rd32_pkg::DIVISOR_W-1:0]    w_mb_ext;
    logic [W-1:0]                        w_d;
    logic [rd32_pkg::DIVIDEND_W-1:0]     w_hi;
    logic                                w_ovf;

    always_comb begin
        n_mag_a = i_dividend[rd32_pkg::DIVIDEND_W-1] ? (~i_dividend + 32'd1) : i_dividend;
        n_mag_b = i_divisor[rd32_pkg::DIVISOR_W-1] ? (~i_divisor + 17'd1) : i_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_minus_a <= i_dividend[rd32_pkg::DIVIDEND_W-1] ^ i_divisor[rd32_pkg::DIVISOR_W-1];
        r_mag_a   <= n_mag_a;
        r_mag_b   <= n_mag_b;
    end

    // divisor magnitude cut or widened to W bits
    assign w_mb_ext = {{W{1'b0}}, r_mag_b};
    assign w_d      = w_mb_ext[W-1:0];
    assign w_hi     = r_mag_a >> W;
    assign w_ovf    = {{W{1'b0}}, w_hi} >= {{rd32_pkg::DIVIDEND_W{1'b0}}, w_d};

    always_comb begin
        n_ctrl.valid = r_valid_a;
        n_ctrl.minus = r_minus_a;
        if (w_d == '0) begin
            n_ctrl.status = rd32_pkg::ST_DIV_ZERO;
        end else if (w_ovf) begin
            n_ctrl.status = rd32_pkg::ST_OVERFLOW;
        end else begin
            n_ctrl.status = rd32_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else begin
            r_ctrl.valid <= n_ctrl.valid;
        end
        r_ctrl.minus  <= n_ctrl.minus;
        r_ctrl.status <= n_ctrl.status;
        r_rem         <= w_hi[W-1:0];
        r_low         <= r_mag_a[W-1:0];
        r_d           <= w_d;
    end

    assign o_ctrl = r_ctrl;
    assign o_rem  = r_rem;
    assign o_low  = r_low;
    assign o_d    = r_d;

endmodule

`default_nettype wire

// ----- rtl/rd32_step.sv -----
// ---------------------------------------------------------------------------
// rd32_step
// One restoring division step: shift in a dividend bit, trial subtract,
// keep or restore, record one quotient bit.
// ---------------------------------------------------------------------------
`default_nettype none

module rd32_step #(
    parameter int W = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rd32_pkg::t_ctrl  i_ctrl,
    input  wire logic [W-1:0]     i_rem,
    input  wire logic [W-1:0]     i_low,
    input  wire logic [W-1:0]     i_q,
    input  wire logic [W-1:0]     i_d,
    output rd32_pkg::t_ctrl       o_ctrl,
    output logic [W-1:0]          o_rem,
    output logic [W-1:0]          o_low,
    output logic [W-1:0]          o_q,
    output logic [W-1:0]          o_d
);

    rd32_pkg::t_ctrl  r_ctrl;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_low;
    logic [W-1:0]     r_q;
    logic [W-1:0]     r_d;

    logic [W:0]       w_trial;
    logic [W:0]       w_diff;
    logic             w_ge;
    logic [W-1:0]     n_rem;
    logic [W-1:0]     n_low;
    logic [W-1:0]     n_q;

    // trial value is one bit wider than the divisor so the shift loses nothing
    assign w_trial = {i_rem, i_low[W-1]};
    assign w_diff  = w_trial - {1'b0, i_d};
    assign w_ge    = w_trial >= {1'b0, i_d};

    always_comb begin
        n_rem = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
        n_low = {i_low[W-2:0], 1'b0};
        n_q   = {i_q[W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else begin
            r_ctrl.valid <= i_ctrl.valid;
        end
        r_ctrl.minus  <= i_ctrl.minus;
        r_ctrl.status <= i_ctrl.status;
        r_rem         <= n_rem;
        r_low         <= n_low;
        r_q           <= n_q;
        r_d           <= i_d;
    end

    assign o_ctrl = r_ctrl;
    assign o_rem  = r_rem;
    assign o_low  = r_low;
    assign o_q    = r_q;
    assign o_d    = r_d;

    a_valid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.valid |=> o_ctrl.valid)
        else $error("request lost in divider step");

    a_rem_below_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.valid && (o_ctrl.status == rd32_pkg::ST_OK)) |-> (o_rem < o_d))
        else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// ----- rtl/restoring_divider_32_by_16.sv -----
// ---------------------------------------------------------------------------
// restoring_divider_32_by_16
// Pipelined signed 32 by 16 restoring divider with zero and overflow status.
// ---------------------------------------------------------------------------
// Accepts one division per clock: busy is always low, so a request is taken
// at every edge where start is high. Each result appears on the o_ ports for
// one cycle with o_strobe high once it has passed through the pipeline:
// two entry stages (magnitudes, then checks), one pipeline stage per
// quotient bit, and an output register that applies the sign. Results come
// back in request order and cannot be held off. Quotient and remainder are
// zero when status reports divide by zero or overflow.
`default_nettype none

module restoring_divider_32_by_16 #(
    parameter int DIVISOR_WIDTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [rd32_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  wire logic [rd32_pkg::DIVISOR_W-1:0]    i_divisor,
    output logic                                   o_strobe,
    output logic [rd32_pkg::QUOT_W-1:0]            o_quotient,
    output logic [rd32_pkg::REM_W-1:0]             o_remainder,
    output logic [1:0]                             o_status
);

    localparam int W   = DIVISOR_WIDTH;
    localparam int LAT = DIVISOR_WIDTH + 3;

    rd32_pkg::t_ctrl  w_ctrl [0:W];
    logic [W-1:0]     w_rem  [0:W];
    logic [W-1:0]     w_low  [0:W];
    logic [W-1:0]     w_q    [0:W];
    logic [W-1:0]     w_d    [0:W];

    logic                              r_strobe;
    logic [rd32_pkg::QUOT_W-1:0]       r_quotient;
    logic [rd32_pkg::REM_W-1:0]        r_remainder;
    rd32_pkg::t_status                 r_status;

    logic [W+rd32_pkg::QUOT_W-1:0]     w_q_ext;
    logic [W+rd32_pkg::REM_W-1:0]      w_rem_ext;
    logic [rd32_pkg::QUOT_W-1:0]       w_q_mag;
    logic [rd32_pkg::QUOT_W-1:0]       n_quotient;
    logic [rd32_pkg::REM_W-1:0]        n_remainder;

    assign busy = 1'b0;

    rd32_front #(.W(W)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_ctrl     (w_ctrl[0]),
        .o_rem      (w_rem[0]),
        .o_low      (w_low[0]),
        .o_d        (w_d[0])
    );

    assign w_q[0] = '0;

    for (genvar s = 0; s < W; s++) begin : g_step
        rd32_step #(.W(W)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[s]),
            .i_rem   (w_rem[s]),
            .i_low   (w_low[s]),
            .i_q     (w_q[s]),
            .i_d     (w_d[s]),
            .o_ctrl  (w_ctrl[s+1]),
            .o_rem   (w_rem[s+1]),
            .o_low   (w_low[s+1]),
            .o_q     (w_q[s+1]),
            .o_d     (w_d[s+1])
        );
    end

    assign w_q_ext   = {{rd32_pkg::QUOT_W{1'b0}}, w_q[W]};
    assign w_rem_ext = {{rd32_pkg::REM_W{1'b0}}, w_rem[W]};
    assign w_q_mag   = w_q_ext[rd32_pkg::QUOT_W-1:0];

    always_comb begin
        if (w_ctrl[W].status == rd32_pkg::ST_OK) begin
            // zero magnitude negates to zero, so no negative zero
            n_quotient  = w_ctrl[W].minus ? (~w_q_mag + 17'd1) : w_q_mag;
            n_remainder = w_rem_ext[rd32_pkg::REM_W-1:0];
        end else begin
            n_quotient  = '0;
            n_remainder = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_ctrl[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quotient  <= n_quotient;
        r_remainder <= n_remainder;
        r_status    <= w_ctrl[W].status;
    end

    assign o_strobe    = r_strobe;
    assign o_quotient  = r_quotient;
    assign o_remainder = r_remainder;
    assign o_status    = r_status;

    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (r_status != rd32_pkg::ST_OK))
        |-> ((o_quotient == '0) && (o_remainder == '0)))
        else $error("nonzero result on error status");

    a_strobe_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result strobe without matching request");

endmodule

`default_nettype wire

// ----- sim/div_result_check.sv -----
// ---------------------------------------------------------------------------
// div_result_check
// Watches the divider's request and result ports, predicts each division
// and compares every result strobe against the oldest outstanding request.
// ---------------------------------------------------------------------------
module div_result_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [rd32_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [rd32_pkg::DIVISOR_W-1:0]      i_divisor,
    input  logic                                i_strobe,
    input  logic [rd32_pkg::QUOT_W-1:0]         i_quotient,
    input  logic [rd32_pkg::REM_W-1:0]          i_remainder,
    input  logic [1:0]                          i_status,
    output int                                  o_pending,
    output int                                  o_mismatches,
    output int                                  o_n_ok,
    output int                                  o_n_zero,
    output int                                  o_n_ovf
);
    timeunit 1ns;
    timeprecision 1ps;

    import rd32_pkg::*;

    typedef struct packed {
        logic [QUOT_W-1:0] quotient;
        logic [REM_W-1:0]  remainder;
        t_status           status;
    } t_div_expect;

    t_div_expect quotients_due[$];

    // magnitudes first, then one restoring step per quotient bit, sign last
    function automatic t_div_expect predict_division(logic [DIVIDEND_W-1:0] dvd,
                                                     logic [DIVISOR_W-1:0] dvs);
        logic [DIVIDEND_W-1:0] mag_dvd;
        logic [DIVISOR_W-1:0]  mag_dvs;
        logic [REM_W-1:0]      dsr;
        logic [REM_W:0]        part;
        logic [REM_W-1:0]      q;
        logic                  negate;
        t_div_expect           r;
        negate  = dvd[DIVIDEND_W-1] ^ dvs[DIVISOR_W-1];
        mag_dvd = dvd[DIVIDEND_W-1] ? -dvd : dvd;
        mag_dvs = dvs[DIVISOR_W-1] ? -dvs : dvs;
        // a 16-bit magnitude register drops the top bit of -65536
        dsr     = mag_dvs[REM_W-1:0];
        r.quotient  = '0;
        r.remainder = '0;
        r.status    = ST_OK;
        if (dsr == '0) begin
            r.status = ST_DIV_ZERO;
        end else if (mag_dvd[DIVIDEND_W-1:REM_W] >= dsr) begin
            r.status = ST_OVERFLOW;
        end else begin
            part = {1'b0, mag_dvd[DIVIDEND_W-1:REM_W]};
            q    = '0;
            for (int b = REM_W - 1; b >= 0; b--) begin
                part = {part[REM_W-1:0], mag_dvd[b]};
                if (part >= {1'b0, dsr}) begin
                    part = part - {1'b0, dsr};
                    q[b] = 1'b1;
                end
            end
            r.quotient  = negate ? -{1'b0, q} : {1'b0, q};
            r.remainder = part[REM_W-1:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_div_expect exp_r;
        if (!i_rst_n) begin
            quotients_due.delete();
            o_pending    = 0;
            o_mismatches = 0;
            o_n_ok       = 0;
            o_n_zero     = 0;
            o_n_ovf      = 0;
        end else begin
            if (start && !busy) begin
                quotients_due.push_back(predict_division(i_dividend, i_divisor));
            end
            if (i_strobe) begin
                if (quotients_due.size() == 0) begin
                    $display("%0t: result with no request outstanding: q=%0h r=%0h st=%0d",
                             $time, i_quotient, i_remainder, i_status);
                    o_mismatches = o_mismatches + 1;
                end else begin
                    exp_r = quotients_due.pop_front();
                    if (i_quotient !== exp_r.quotient) begin
                        $display("%0t: quotient expected %0h actual %0h",
                                 $time, exp_r.quotient, i_quotient);
                        o_mismatches = o_mismatches + 1;
                    end
                    if (i_remainder !== exp_r.remainder) begin
                        $display("%0t: remainder expected %0h actual %0h",
                                 $time, exp_r.remainder, i_remainder);
                        o_mismatches = o_mismatches + 1;
                    end
                    if (i_status !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, i_status);
                        o_mismatches = o_mismatches + 1;
                    end
                    case (exp_r.status)
                        ST_OK:       o_n_ok   = o_n_ok + 1;
                        ST_DIV_ZERO: o_n_zero = o_n_zero + 1;
                        default:     o_n_ovf  = o_n_ovf + 1;
                    endcase
                end
            end
            o_pending = quotients_due.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Drives the 32 by 16 restoring divider with directed corner divisions and
// random operands, and leaves all result checking to div_result_check.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rd32_pkg::*;

    localparam int N_RANDOM  = 1430;
    localparam int LATENCY   = 16 + 3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [DIVIDEND_W-1:0] i_dividend;
    logic [DIVISOR_W-1:0]  i_divisor;
    logic                  o_strobe;
    logic [QUOT_W-1:0]     o_quotient;
    logic [REM_W-1:0]      o_remainder;
    logic [1:0]            o_status;
    logic                  req_taken;
    bit                    no_idle;
    int                    pending;
    int                    mismatches;
    int                    n_ok;
    int                    n_zero;
    int                    n_ovf;

    restoring_divider_32_by_16 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_strobe    (o_strobe),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder),
        .o_status    (o_status)
    );

    div_result_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_dividend   (i_dividend),
        .i_divisor    (i_divisor),
        .i_strobe     (o_strobe),
        .i_quotient   (o_quotient),
        .i_remainder  (o_remainder),
        .i_status     (o_status),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_n_ok       (n_ok),
        .o_n_zero     (n_zero),
        .o_n_ovf      (n_ovf)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // request handshake seen at the edge, read back at the following falling edge
    always @(posedge i_clk) begin
        req_taken <= start && !busy && i_rst_n;
    end

    initial begin
        #2ms;
        $display("testbench NOT OK");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_division(input logic [DIVIDEND_W-1:0] dvd,
                                 input logic [DIVISOR_W-1:0] dvs);
        int gap;
        gap = 0;
        // each cycle idles with the same odds
        while (!no_idle && ($urandom_range(0, 99) < 24)) begin
            gap = gap + 1;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start      <= 1'b1;
        i_dividend <= dvd;
        i_divisor  <= dvs;
        do @(negedge i_clk); while (!req_taken);
    endtask

    task automatic wait_all_returned;
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // mostly divisions that fit, some near the overflow edge, some by zero, some noise
    task automatic pick_operands(output logic [DIVIDEND_W-1:0] dvd,
                                 output logic [DIVISOR_W-1:0] dvs);
        int          pick;
        int          bits;
        logic [16:0] mag_b;
        logic [31:0] mag_a;
        logic [15:0] upper;
        int          top;
        pick = $urandom_range(0, 99);
        bits = $urandom_range(1, 16);
        mag_b = {1'b0, 16'($urandom & ((32'd1 << bits) - 1))};
        if (mag_b == 0) mag_b = 17'd1;
        if (pick < 70) begin
            top   = (mag_b - 1 > 32'h7FFF) ? 32'h7FFF : mag_b - 1;
            upper = 16'($urandom_range(0, top));
        end else if (pick < 80) begin
            upper = $urandom_range(0, 1) ? mag_b[15:0] : mag_b[15:0] - 16'd1;
            upper = upper & 16'h7FFF;
        end else begin
            upper = 16'($urandom);
        end
        mag_a = {upper, 16'($urandom)};
        dvd   = $urandom_range(0, 1) ? -mag_a : mag_a;
        dvs   = $urandom_range(0, 1) ? -mag_b : mag_b;
        if (pick >= 80 && pick < 85) begin
            dvs = $urandom_range(0, 1) ? 17'h10000 : 17'h00000;
        end else if (pick >= 85) begin
            dvd = $urandom;
            dvs = 17'($urandom);
        end
    endtask

    initial begin
        logic [DIVIDEND_W-1:0] dvd;
        logic [DIVISOR_W-1:0]  dvs;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_dividend = '0;
        i_divisor  = '0;
        no_idle    = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // signs, zero divisors, overflow edges, extreme operands
        send_division(32'd100, 17'd7);
        send_division(-32'sd100, 17'd7);
        send_division(32'd100, -17'sd7);
        send_division(-32'sd100, -17'sd7);
        send_division(32'd12345, 17'd0);
        send_division(32'hFFFF_FFFF, 17'd0);
        send_division(32'd5, 17'h10000);
        send_division(32'h7FFF_FFFF, 17'd65535);
        send_division(32'h8000_0000, 17'd65535);
        send_division(32'h8000_0000, -17'sd65535);
        send_division(32'h8000_0000, 17'd32768);
        send_division(32'h7FFF_FFFF, 17'd32767);
        send_division(32'h0001_0000, 17'd1);
        send_division(32'h0000_FFFF, 17'd1);
        send_division(-32'sd65535, 17'd1);
        send_division(32'd0, -17'sd5);
        send_division(-32'sd3, 17'd5);
        send_division(32'd3, -17'sd5);
        send_division(32'd2147450879, 17'd65535);
        send_division(32'hFFFF_FFFF, 17'd65535);
        send_division(32'h7FFF_FFFF, -17'sd1);
        send_division(32'h0000_FFFF, 17'h1FFFF);
        wait_all_returned();

        for (int n = 0; n < N_RANDOM; n++) begin
            no_idle = (n >= 500 && n < 800);
            if (n == 1000) wait_all_returned();
            pick_operands(dvd, dvs);
            send_division(dvd, dvs);
        end
        wait_all_returned();
        repeat (LATENCY + 6) @(negedge i_clk);

        $display("checked %0d divisions: %0d in range, %0d by zero, %0d overflowed",
                 n_ok + n_zero + n_ovf, n_ok, n_zero, n_ovf);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
